// ===== rtl/core/asg_pkg.sv =====
// Shared types and constants for the greedy activity selection unit.
package asg_pkg;

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
  } entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK
  } state_t;

endpackage

// ===== rtl/core/asg_if.sv =====
// Valid/ready channel interfaces for activities in and chosen activities out.
interface asg_act_if;
  logic                      valid;
  logic                      ready;
  logic [asg_pkg::ID_W-1:0]   activity_id;
  logic [asg_pkg::TIME_W-1:0] start_time;
  logic [asg_pkg::TIME_W-1:0] finish_time;
  logic                      last_item;

  modport source (output valid, activity_id, start_time, finish_time, last_item,
                  input ready);
  modport sink   (input valid, activity_id, start_time, finish_time, last_item,
                  output ready);
endinterface

interface asg_choice_if;
  logic                      valid;
  logic                      ready;
  logic [asg_pkg::ID_W-1:0]   chosen_id;
  logic [asg_pkg::TIME_W-1:0] chosen_start;
  logic [asg_pkg::TIME_W-1:0] chosen_finish;
  logic                      final_choice;
  logic                      dropped_items;

  modport source (output valid, chosen_id, chosen_start, chosen_finish, final_choice,
                  dropped_items, input ready);
  modport sink   (input valid, chosen_id, chosen_start, chosen_finish, final_choice,
                  dropped_items, output ready);
endinterface

// ===== rtl/core/activity_selection_greedy_unit.sv =====
// Greedy activity selection: store a set, then emit the greedy schedule by finish time.
//
//  channel    | dir | transaction
//  -----------+-----+-----------------------------------------------------------
//  in_chan    | in  | activity_id, start_time, finish_time, last_item
//  out_chan   | out | chosen_id, chosen_start, chosen_finish, final_choice,
//             |     | dropped_items
//
// Loading takes one activity per cycle, written into the activity memory in arrival order.
// After the last item, each pick is one pass over the n stored entries through the
// memory's single read port, and a set takes (selected + 1) passes.
// in_chan.ready is low from the last item until the final result enters the output
// register; a stalled output register holds the selection between passes.
// Reset (rst_n low, synchronous) empties the set; memory contents need no reset.
module activity_selection_greedy_unit #(
  parameter int MAX_ACTIVITIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  asg_act_if.sink      in_chan,
  asg_choice_if.source out_chan
);

  localparam int CW = $clog2(MAX_ACTIVITIES + 1);
  localparam int IW = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;

  asg_pkg::entry_t mem [0:MAX_ACTIVITIES-1];

  asg_pkg::state_t st_r, st_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic            rvalid_r, rvalid_nxt;
  logic [IW-1:0]   ridx_r;
  asg_pkg::entry_t rdata_r;
  logic            best_valid_r, best_valid_nxt;
  asg_pkg::entry_t best_r, best_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  logic            have_pend_r, have_pend_nxt;
  asg_pkg::entry_t pend_r, pend_nxt;
  logic [IW-1:0]   pend_idx_r, pend_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  asg_pkg::entry_t out_r, out_nxt;
  logic            out_final_r, out_final_nxt;
  logic            out_drop_r, out_drop_nxt;

  logic            in_acc;
  logic            mem_we;
  logic            rd_en;
  logic            qual;
  logic            slot_free;
  asg_pkg::entry_t in_entry;

  assign in_entry.id     = in_chan.activity_id;
  assign in_entry.start  = in_chan.start_time;
  assign in_entry.finish = in_chan.finish_time;

  assign in_chan.ready = (st_r == asg_pkg::ST_LOAD);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign mem_we        = in_acc && (cnt_r < CW'(MAX_ACTIVITIES));
  assign rd_en         = (st_r == asg_pkg::ST_SCAN) && (rd_cnt_r < cnt_r);
  assign slot_free     = !out_valid_r || out_chan.ready;

  // First pass takes any entry; later passes need a compatible start and a later sort key.
  assign qual = !have_pend_r ||
                ((rdata_r.start >= pend_r.finish) &&
                 ({rdata_r.finish, ridx_r} > {pend_r.finish, pend_idx_r}));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IW-1:0]] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_cnt_r[IW-1:0]];
    ridx_r  <= rd_cnt_r[IW-1:0];
  end

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    rd_cnt_nxt     = rd_cnt_r;
    rvalid_nxt     = rd_en;
    best_valid_nxt = best_valid_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    have_pend_nxt  = have_pend_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_nxt        = out_r;
    out_final_nxt  = out_final_r;
    out_drop_nxt   = out_drop_r;

    case (st_r)
      asg_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (mem_we) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.last_item) begin
            st_nxt         = asg_pkg::ST_SCAN;
            rd_cnt_nxt     = '0;
            best_valid_nxt = 1'b0;
            have_pend_nxt  = 1'b0;
          end
        end
      end

      asg_pkg::ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        // Scan ascends by index, so strict less keeps the earliest of equal finishes.
        if (rvalid_r && qual && (!best_valid_r || (rdata_r.finish < best_r.finish))) begin
          best_valid_nxt = 1'b1;
          best_nxt       = rdata_r;
          best_idx_nxt   = ridx_r;
        end
        if (!rd_en && !rvalid_r) begin
          st_nxt = asg_pkg::ST_PICK;
        end
      end

      asg_pkg::ST_PICK: begin
        if (!have_pend_r) begin
          have_pend_nxt  = 1'b1;
          pend_nxt       = best_r;
          pend_idx_nxt   = best_idx_r;
          rd_cnt_nxt     = '0;
          best_valid_nxt = 1'b0;
          st_nxt         = asg_pkg::ST_SCAN;
        end else if (slot_free) begin
          // Emit the held choice; it is final when this pass found no successor.
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_final_nxt = !best_valid_r;
          out_drop_nxt  = ovf_r;
          if (best_valid_r) begin
            pend_nxt       = best_r;
            pend_idx_nxt   = best_idx_r;
            rd_cnt_nxt     = '0;
            best_valid_nxt = 1'b0;
            st_nxt         = asg_pkg::ST_SCAN;
          end else begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            st_nxt  = asg_pkg::ST_LOAD;
          end
        end
      end

      default: begin
        st_nxt = asg_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= asg_pkg::ST_LOAD;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      rd_cnt_r     <= '0;
      rvalid_r     <= 1'b0;
      best_valid_r <= 1'b0;
      have_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      rvalid_r     <= rvalid_nxt;
      best_valid_r <= best_valid_nxt;
      have_pend_r  <= have_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_idx_r  <= best_idx_nxt;
    pend_r      <= pend_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_r       <= out_nxt;
    out_final_r <= out_final_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.chosen_id     = out_r.id;
  assign out_chan.chosen_start  = out_r.start;
  assign out_chan.chosen_finish = out_r.finish;
  assign out_chan.final_choice  = out_final_r;
  assign out_chan.dropped_items = out_drop_r;

endmodule

// ===== rtl/core/asg_checker.sv =====
// Port-level assertions for the greedy activity selection unit, with its bind.
module asg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last_item,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [asg_pkg::ID_W-1:0]   out_chosen_id,
  input logic [asg_pkg::TIME_W-1:0] out_chosen_finish,
  input logic                       out_final_choice
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_chosen_id) && $stable(out_chosen_finish))
    else $error("stalled result changed");

  // Close the input after the last item of a set.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input open after last item");

  // Non-final results only appear while selection is still running.
  a_mid_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_choice |-> !in_ready)
    else $error("input open during selection");

endmodule

bind activity_selection_greedy_unit asg_checker u_asg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_last_item      (in_chan.last_item),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_chosen_id     (out_chan.chosen_id),
  .out_chosen_finish (out_chan.chosen_finish),
  .out_final_choice  (out_chan.final_choice)
);
